// File: rtl/lpfr_pkg.sv
package lpfr_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
  localparam int CRC_BYTES   = 2;
  localparam logic [7:0] START_BYTE = 8'hFB;

  localparam int QUEUE_DEPTH = 3;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_TAKE  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } lpfr_action_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_LENGTH   = 3'd1,
    PH_COMMAND  = 3'd2,
    PH_PAYLOAD  = 3'd3,
    PH_RECEIVED = 3'd4,
    PH_DIGESTED = 3'd5
  } lpfr_phase_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] byte_value;
    logic [5:0] read_index;
  } lpfr_req_t;

  typedef struct packed {
    logic [2:0] parser_state;
    logic       frame_taken;
    logic [7:0] frame_length;
    logic [7:0] frame_command;
    logic [6:0] stored_count;
    logic [7:0] read_byte;
  } lpfr_res_t;

  typedef struct packed {
    logic      valid;
    lpfr_res_t res;
  } lpfr_push_t;

endpackage

// File: rtl/length_prefixed_frame_receiver.sv
// Length-prefixed serial frame receiver.
// Request channel: req_valid_i / req_stall_o / req_i carry one action per
// request: a received byte, take frame, reset parser, or read a stored byte.
// Result channel: res_valid_o / res_stall_i / res_o return exactly one result
// per request, in order: phase after the request, take flag, held length and
// command, stored byte count, and the read byte (zero unless a read hit).
// A result passes through the parser's result register and then a queue entry
// before the result channel offers it.
// Throughput: one request per cycle while results are taken; the parser
// state updates in the cycle of acceptance, the store write and read use one
// port each, and a three-entry result queue decouples the two channels.
// When the receiver stalls, results collect in the queue and req_stall_o
// rises once the queue plus the result in flight would fill it; results are
// never lost or repeated.
// Reset: phase idle, held length, command and count zero, queue empty. The
// byte store is not cleared; only entries below the count are ever read.
module length_prefixed_frame_receiver (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_stall_o,
  input  lpfr_pkg::lpfr_req_t req_i,
  output logic                res_valid_o,
  input  logic                res_stall_i,
  output lpfr_pkg::lpfr_res_t res_o
);
  import lpfr_pkg::*;

  logic       accept;
  lpfr_push_t push;

  assign accept = req_valid_i && !req_stall_o;

  lpfr_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i),
    .push_o   (push)
  );

  lpfr_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .req_stall_o (req_stall_o),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .res_o       (res_o)
  );

endmodule

// File: rtl/lpfr_parser.sv
module lpfr_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  lpfr_pkg::lpfr_req_t req_i,
  output lpfr_pkg::lpfr_push_t push_o
);
  import lpfr_pkg::*;

  lpfr_phase_e        phase_q, phase_d;
  logic [7:0]         length_q, length_d;
  logic [7:0]         command_q, command_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [COUNT_W-1:0] count_inc;
  logic               store_full;
  logic               frame_done;
  logic               wr_en;
  logic               taken;
  logic               hit;
  lpfr_action_e       act;

  logic [7:0]         mem_q [STORE_DEPTH];
  logic [7:0]         rdata_q;
  logic               hit_q;
  logic               valid_q;
  lpfr_res_t          res_q, res_d;

  assign act        = lpfr_action_e'(req_i.action);
  assign store_full = int'(count_q) >= STORE_DEPTH;
  assign count_inc  = count_q + COUNT_W'(1);
  assign frame_done = int'(count_inc) >= int'(length_q) + CRC_BYTES;
  assign hit        = (int'(req_i.read_index) < int'(count_q))
                   && (int'(req_i.read_index) < STORE_DEPTH);

  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      case (act)
        ACT_BYTE: begin
          case (phase_q)
            PH_IDLE: begin
              if (req_i.byte_value == START_BYTE) phase_d = PH_LENGTH;
            end
            PH_LENGTH:  phase_d = PH_COMMAND;
            PH_COMMAND: phase_d = PH_PAYLOAD;
            PH_PAYLOAD: begin
              if (store_full) phase_d = PH_IDLE;
              else if (frame_done) phase_d = PH_RECEIVED;
            end
            default: ;
          endcase
        end
        ACT_TAKE: begin
          if (phase_q == PH_RECEIVED) phase_d = PH_DIGESTED;
        end
        ACT_CLEAR: phase_d = PH_IDLE;
        default: ;
      endcase
    end
  end

  always_comb begin
    length_d  = length_q;
    command_d = command_q;
    count_d   = count_q;
    wr_en     = 1'b0;
    taken     = 1'b0;
    if (accept_i) begin
      case (act)
        ACT_BYTE: begin
          case (phase_q)
            PH_LENGTH:  length_d = req_i.byte_value;
            PH_COMMAND: begin
              command_d = req_i.byte_value;
              count_d   = '0;
            end
            PH_PAYLOAD: begin
              if (!store_full) begin
                wr_en   = 1'b1;
                count_d = count_inc;
              end
            end
            default: ;
          endcase
        end
        ACT_TAKE: taken = (phase_q == PH_RECEIVED);
        default: ;
      endcase
    end
  end

  always_comb begin
    res_d               = '0;
    res_d.parser_state  = phase_d;
    res_d.frame_taken   = taken;
    res_d.frame_length  = length_d;
    res_d.frame_command = command_d;
    res_d.stored_count  = 7'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      length_q  <= '0;
      command_q <= '0;
      count_q   <= '0;
      valid_q   <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      length_q  <= length_d;
      command_q <= command_d;
      count_q   <= count_d;
      valid_q   <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      res_q <= res_d;
      hit_q <= (act == ACT_READ) && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[count_q[ADDR_W-1:0]] <= req_i.byte_value;
    if (accept_i) rdata_q <= mem_q[ADDR_W'(req_i.read_index)];
  end

  always_comb begin
    push_o           = '0;
    push_o.valid     = valid_q;
    push_o.res       = res_q;
    push_o.res.read_byte = hit_q ? rdata_q : 8'd0;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= STORE_DEPTH)
    else $error("stored byte count beyond store depth");

  a_taken_digested: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && res_q.frame_taken |-> res_q.parser_state == PH_DIGESTED)
    else $error("frame taken without digested phase");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && act == ACT_BYTE && phase_q == PH_PAYLOAD && store_full
      |=> phase_q == PH_IDLE && $stable(count_q))
    else $error("byte into full store not dropped");

  a_take_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken |=> phase_q == PH_DIGESTED)
    else $error("take did not move parser to digested");

endmodule

// File: rtl/lpfr_out_queue.sv
module lpfr_out_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lpfr_pkg::lpfr_push_t push_i,
  output logic                 req_stall_o,
  output logic                 res_valid_o,
  input  logic                 res_stall_i,
  output lpfr_pkg::lpfr_res_t  res_o
);
  import lpfr_pkg::*;

  lpfr_res_t         buf_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              pop;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    n = (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + QPTR_W'(1);
    return n;
  endfunction

  assign res_valid_o = cnt_q != '0;
  assign res_o       = buf_q[rd_ptr_q];
  assign pop         = res_valid_o && !res_stall_i;
  // hold the request side while the queue plus the result in flight could overflow
  assign req_stall_o = (int'(cnt_q) + int'(push_i.valid)) >= QUEUE_DEPTH;

  always_comb begin
    wr_ptr_d = push_i.valid ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i.valid && !pop) cnt_d = cnt_q + QCNT_W'(1);
    else if (!push_i.valid && pop) cnt_d = cnt_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) buf_q[wr_ptr_q] <= push_i.res;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> int'(cnt_q) < QUEUE_DEPTH || pop)
    else $error("result pushed into full queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= QUEUE_DEPTH)
    else $error("queue count beyond depth");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid && !pop |=> cnt_q == $past(cnt_q) + QCNT_W'(1))
    else $error("queue count lost a push");

endmodule
